// ----- rtl/rswl_pkg.sv -----
// Shared types, codes and limits for the stop-and-wait radio link controller.
// No dependencies; imported by every module of the block.
package rswl_pkg;

	localparam int HEADER_BYTES   = 11;
	localparam int MAX_PAYLOAD    = 32;
	localparam int MAX_CMD_PARAMS = 7;

	localparam int CFG_ADDR_W = 3;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 104;

	localparam logic [31:0] NODE_ID_RESET = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_INIT        = 4'd0,
		ST_RECEIVE     = 4'd1,
		ST_RECEIVING   = 4'd2,
		ST_SENDING_ACK = 4'd3,
		ST_PROCESS     = 4'd4,
		ST_SEND        = 4'd5,
		ST_SENDING     = 4'd6,
		ST_WAIT_ACK    = 4'd7,
		ST_IDLE        = 4'd8
	} link_state_t;

	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_INIT     = 3'd1,
		CMD_RX_ON    = 3'd2,
		CMD_RX_OFF   = 3'd3,
		CMD_SEND     = 3'd4,
		CMD_SEND_ACK = 3'd5,
		CMD_STANDBY  = 3'd6
	} drv_cmd_t;

	typedef enum logic [2:0] {
		KIND_TICK     = 3'd0,
		KIND_PKT      = 3'd1,
		KIND_RX_DONE  = 3'd2,
		KIND_TX_DONE  = 3'd3,
		KIND_APP_DATA = 3'd4,
		KIND_APP_CMD  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		MT_DATA  = 2'd0,
		MT_CMD   = 2'd1,
		MT_ACK   = 2'd2,
		MT_OTHER = 2'd3
	} pkt_type_t;

	typedef enum logic [1:0] {
		DLV_NONE = 2'd0,
		DLV_DATA = 2'd1,
		DLV_CMD  = 2'd2
	} deliver_t;

	localparam logic [0:0] REG_ROOT_MODE = 1'b0;
	localparam logic [0:0] REG_NODE_ID   = 1'b1;

	typedef struct packed {
		logic        root_mode;
		logic [31:0] node_id;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [7:0]        length;
		logic [1:0]        pkt_type;
		logic [31:0]       dest_id;
		logic [31:0]       src_addr;
		logic [7:0]        msg_num;
		logic [7:0]        ack_num;
		logic signed [7:0] rssi;
		logic              sent_flag;
		logic              driver_ok;
	} in_item_t;

	typedef struct packed {
		logic [3:0]        link_state;
		logic [2:0]        driver_cmd;
		logic [1:0]        deliver;
		logic signed [7:0] deliver_rssi;
		logic [31:0]       deliver_source;
		logic [31:0]       reply_dest;
		logic [7:0]        reply_num;
		logic              append_accepted;
		logic              outgoing_pending;
		logic [7:0]        outgoing_num;
	} result_t;

endpackage

// ----- rtl/rswl_cfg.sv -----
// APB configuration registers: root_mode at 0x0, node_id at 0x4.
// Depends on rswl_pkg.
module rswl_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rswl_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output rswl_pkg::cfg_t                   cfg
);
	import rswl_pkg::*;

	logic        root_mode_q;
	logic [31:0] node_id_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_mode_q <= 1'b0;
			node_id_q   <= NODE_ID_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_NODE_ID) begin
				node_id_q <= pwdata;
			end else begin
				root_mode_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NODE_ID) ? node_id_q : {31'd0, root_mode_q};

	assign cfg.root_mode = root_mode_q;
	assign cfg.node_id   = node_id_q;

endmodule

// ----- rtl/rswl_step.sv -----
// Link state registers and the single-pass transition logic for one event.
// Depends on rswl_pkg.
module rswl_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  rswl_pkg::in_item_t item,
	input  rswl_pkg::cfg_t     cfg,
	output rswl_pkg::result_t  res
);
	import rswl_pkg::*;

	link_state_t       fsm_q, fsm_d;
	logic              out_valid_q, out_valid_d;
	logic [31:0]       out_dest_q, out_dest_d;
	logic [7:0]        out_number_q, out_number_d;
	logic [7:0]        next_number_q, next_number_d;
	logic              in_valid_q, in_valid_d;
	logic [1:0]        in_type_q, in_type_d;
	logic [31:0]       in_source_q, in_source_d;
	logic signed [7:0] in_rssi_q, in_rssi_d;
	logic              ack_due_q, ack_due_d;
	logic [31:0]       ack_dest_q, ack_dest_d;
	logic [7:0]        ack_number_q, ack_number_d;

	drv_cmd_t          cmd;
	deliver_t          dlv;
	logic              acc;
	logic              root;
	logic              ok;
	logic              hdr_ok;
	logic [7:0]        app_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q         <= ST_INIT;
			out_valid_q   <= 1'b0;
			out_dest_q    <= '0;
			out_number_q  <= '0;
			next_number_q <= '0;
			in_valid_q    <= 1'b0;
			in_type_q     <= '0;
			in_source_q   <= '0;
			in_rssi_q     <= '0;
			ack_due_q     <= 1'b0;
			ack_dest_q    <= '0;
			ack_number_q  <= '0;
		end else if (adv) begin
			fsm_q         <= fsm_d;
			out_valid_q   <= out_valid_d;
			out_dest_q    <= out_dest_d;
			out_number_q  <= out_number_d;
			next_number_q <= next_number_d;
			in_valid_q    <= in_valid_d;
			in_type_q     <= in_type_d;
			in_source_q   <= in_source_d;
			in_rssi_q     <= in_rssi_d;
			ack_due_q     <= ack_due_d;
			ack_dest_q    <= ack_dest_d;
			ack_number_q  <= ack_number_d;
		end
	end

	assign root   = cfg.root_mode;
	assign ok     = item.driver_ok;
	assign hdr_ok = (item.length >= 8'(HEADER_BYTES)) && (item.dest_id == cfg.node_id);
	assign app_limit = (item.kind == KIND_APP_DATA) ? 8'(MAX_PAYLOAD) : 8'(MAX_CMD_PARAMS);

	always_comb begin
		fsm_d         = fsm_q;
		out_valid_d   = out_valid_q;
		out_dest_d    = out_dest_q;
		out_number_d  = out_number_q;
		next_number_d = next_number_q;
		in_valid_d    = in_valid_q;
		in_type_d     = in_type_q;
		in_source_d   = in_source_q;
		in_rssi_d     = in_rssi_q;
		ack_due_d     = ack_due_q;
		ack_dest_d    = ack_dest_q;
		ack_number_d  = ack_number_q;
		cmd           = CMD_NONE;
		dlv           = DLV_NONE;
		acc           = 1'b0;
		res           = '0;

		case (item.kind)
			KIND_TICK: begin
				case (fsm_q)
					ST_INIT: begin
						cmd   = CMD_INIT;
						fsm_d = ST_IDLE;
					end
					ST_RECEIVE: begin
						cmd       = CMD_RX_ON;
						ack_due_d = 1'b0;
						fsm_d     = ok ? ST_RECEIVING : ST_IDLE;
					end
					ST_PROCESS: begin
						fsm_d = ST_IDLE;
						if (in_valid_q) begin
							if (root && out_valid_q && (out_dest_q == in_source_q))
								fsm_d = ST_SEND;
							dlv                = (in_type_q == MT_DATA) ? DLV_DATA : DLV_CMD;
							res.deliver_rssi   = in_rssi_q;
							res.deliver_source = in_source_q;
							in_valid_d         = 1'b0;
							in_type_d          = '0;
							in_source_d        = '0;
							in_rssi_d          = '0;
						end
					end
					ST_SEND: begin
						if (!out_valid_q) begin
							fsm_d = root ? ST_RECEIVE : ST_IDLE;
						end else begin
							cmd   = CMD_SEND;
							fsm_d = ok ? ST_SENDING : ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (out_valid_q)
							fsm_d = ST_SEND;
						else if (root)
							fsm_d = ST_RECEIVE;
						else
							cmd = CMD_STANDBY;
					end
					default: ;
				endcase
			end
			KIND_PKT: begin
				if (hdr_ok) begin
					if (item.pkt_type == MT_ACK && fsm_q == ST_WAIT_ACK) begin
						if (item.ack_num == out_number_q)
							out_valid_d = 1'b0;
						cmd = CMD_RX_OFF;
					end else if ((item.pkt_type == MT_DATA || item.pkt_type == MT_CMD)
							&& fsm_q == ST_RECEIVING) begin
						in_valid_d   = 1'b1;
						in_type_d    = item.pkt_type;
						in_source_d  = item.src_addr;
						in_rssi_d    = item.rssi;
						ack_dest_d   = item.src_addr;
						ack_number_d = item.msg_num;
						ack_due_d    = 1'b1;
						cmd          = CMD_RX_OFF;
					end
				end
			end
			KIND_RX_DONE: begin
				if (fsm_q == ST_WAIT_ACK) begin
					fsm_d = root ? ST_IDLE : ST_RECEIVE;
				end else if (fsm_q == ST_RECEIVING) begin
					if (ack_due_q) begin
						cmd            = CMD_SEND_ACK;
						res.reply_dest = ack_dest_q;
						res.reply_num  = ack_number_q;
						fsm_d          = ok ? ST_SENDING_ACK : ST_PROCESS;
					end else begin
						fsm_d = ST_IDLE;
					end
				end
			end
			KIND_TX_DONE: begin
				if (fsm_q == ST_SENDING) begin
					if (item.sent_flag) begin
						cmd   = CMD_RX_ON;
						fsm_d = ok ? ST_WAIT_ACK : ST_IDLE;
					end else begin
						fsm_d = ST_IDLE;
					end
				end else if (fsm_q == ST_SENDING_ACK) begin
					fsm_d = ST_PROCESS;
				end
			end
			KIND_APP_DATA, KIND_APP_CMD: begin
				if (!out_valid_q && item.length != 8'd0 && item.length <= app_limit) begin
					out_valid_d   = 1'b1;
					out_dest_d    = item.dest_id;
					out_number_d  = next_number_q;
					next_number_d = next_number_q + 8'd1;
					acc           = 1'b1;
				end
			end
			default: ;
		endcase

		res.link_state       = fsm_d;
		res.driver_cmd       = cmd;
		res.deliver          = dlv;
		res.append_accepted  = acc;
		res.outgoing_pending = out_valid_d;
		res.outgoing_num     = out_valid_d ? out_number_d : 8'd0;
	end

endmodule

// ----- rtl/radio_stop_and_wait_link.sv -----
// Top level of the stop-and-wait radio link controller: input register,
// result register and APB port. Depends on rswl_pkg, rswl_cfg, rswl_step.
//
//  channel  | direction | transfer / write      | payload
//  s_axis   | in        | s_tvalid & s_tready   | s_tuser kind, s_tdata event fields
//  m_axis   | out       | m_tvalid & m_tready   | m_tdata result fields
//  apb      | in        | psel&penable&pwrite   | root_mode @0x0, node_id @0x4
//
// One event per cycle sustained while m_tready is high; each event passes the input register, then the result register.
// The transition runs between the input register and the result register.
// Reset: state init, nothing pending, root_mode 0, node_id all ones.
// m_tready low holds the result; intake stops once the input register fills.
module radio_stop_and_wait_link (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [7:0] length, [9:8] pkt_type, [41:10] dest_id, [73:42] src_addr,
	// [81:74] msg_num, [89:82] ack_num, [97:90] rssi, [98] sent_flag,
	// [99] driver_ok, [103:100] zero
	input  logic [rswl_pkg::IN_DATA_W-1:0]        s_tdata,
	// [2:0] kind
	input  logic [2:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [3:0] link_state, [6:4] driver_cmd, [8:7] deliver, [16:9] deliver_rssi,
	// [48:17] deliver_source, [80:49] reply_dest, [88:81] reply_num,
	// [89] append_accepted, [90] outgoing_pending, [98:91] outgoing_num,
	// [103:99] zero
	output logic [rswl_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [rswl_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import rswl_pkg::*;

	cfg_t     cfg;
	in_item_t item_s1, item_in;
	logic     vld_s1;
	result_t  res_c, res_s2;
	logic     vld_s2;
	logic     adv;

	assign item_in.kind      = s_tuser;
	assign item_in.length    = s_tdata[7:0];
	assign item_in.pkt_type  = s_tdata[9:8];
	assign item_in.dest_id   = s_tdata[41:10];
	assign item_in.src_addr  = s_tdata[73:42];
	assign item_in.msg_num   = s_tdata[81:74];
	assign item_in.ack_num   = s_tdata[89:82];
	assign item_in.rssi      = s_tdata[97:90];
	assign item_in.sent_flag = s_tdata[98];
	assign item_in.driver_ok = s_tdata[99];

	assign adv      = vld_s1 & (~vld_s2 | m_tready);
	assign s_tready = ~vld_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (m_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_in;
		if (adv)
			res_s2 <= res_c;
	end

	rswl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rswl_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {5'd0, res_s2.outgoing_num, res_s2.outgoing_pending,
		res_s2.append_accepted, res_s2.reply_num, res_s2.reply_dest,
		res_s2.deliver_source, res_s2.deliver_rssi, res_s2.deliver,
		res_s2.driver_cmd, res_s2.link_state};

endmodule

// ----- rtl/rswl_checker.sv -----
// Port-level checks for radio_stop_and_wait_link, bound to the top level.
// Depends on rswl_pkg.
module rswl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [rswl_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import rswl_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_num_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[90] |-> m_tdata[98:91] == 8'd0)
		else $error("outgoing_num nonzero with nothing pending");

	a_append: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[89] |-> m_tdata[90])
		else $error("append accepted but nothing pending");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8:7] != DLV_NONE |->
			m_tdata[3:0] == ST_IDLE || m_tdata[3:0] == ST_SEND)
		else $error("delivery outside process exit");

	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:4] == CMD_SEND_ACK |->
			m_tdata[3:0] == ST_SENDING_ACK || m_tdata[3:0] == ST_PROCESS)
		else $error("ack sent from wrong state");

endmodule

bind radio_stop_and_wait_link rswl_checker u_rswl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for radio_stop_and_wait_link: directed and random event streams checked
// against a behavioral model of the link state machine. Depends on rswl_pkg and the RTL.
module tb;
	import rswl_pkg::*;

	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;
	localparam logic [CFG_ADDR_W-1:0] ADDR_ROOT_MODE = {REG_ROOT_MODE, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_NODE_ID   = {REG_NODE_ID, 2'b00};
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// [7:0] length, [9:8] pkt_type, [41:10] dest_id, [73:42] src_addr, [81:74] msg_num,
	// [89:82] ack_num, [97:90] rssi, [98] sent_flag, [99] driver_ok, [103:100] zero
	logic [IN_DATA_W-1:0]  s_tdata;
	// [2:0] kind
	logic [2:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [3:0] link_state, [6:4] driver_cmd, [8:7] deliver, [16:9] deliver_rssi,
	// [48:17] deliver_source, [80:49] reply_dest, [88:81] reply_num,
	// [89] append_accepted, [90] outgoing_pending, [98:91] outgoing_num
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	radio_stop_and_wait_link dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	// link model state and configuration
	bit                cfg_root = 1'b0;
	logic [31:0]       cfg_node = NODE_ID_RESET;
	link_state_t       st = ST_INIT;
	bit                out_valid = 1'b0;
	logic [31:0]       out_dest = '0;
	logic [7:0]        out_number = '0;
	logic [7:0]        next_number = '0;
	bit                number_wrapped = 1'b0;
	bit                in_valid = 1'b0;
	logic [1:0]        in_type = '0;
	logic [31:0]       in_source = '0;
	logic signed [7:0] in_rssi = '0;
	bit                ack_due = 1'b0;
	logic [31:0]       ack_dest = '0;
	logic [7:0]        ack_number = '0;

	result_t     link_reports_due[$];
	result_t     got_r, want_r;
	int unsigned mismatches = 0;
	int unsigned reports_seen = 0;
	int unsigned stalled_cycles = 0;
	bit          idling = 1'b1;
	bit          hold_req = 1'b0;
	int          noise_pct = 25;
	int          fail_pct = 10;

	function automatic bit take_append(input in_item_t ev, input int limit);
		if (out_valid || ev.length < 1 || ev.length > limit)
			return 1'b0;
		out_valid = 1'b1;
		out_dest = ev.dest_id;
		out_number = next_number;
		next_number = next_number + 8'd1;
		if (next_number == 8'd0)
			number_wrapped = 1'b1;
		return 1'b1;
	endfunction

	function automatic result_t predict_link_step(input in_item_t ev);
		result_t r;
		r = '0;
		case (ev.kind)
			KIND_TICK: begin
				case (st)
					ST_INIT: begin
						r.driver_cmd = CMD_INIT;
						st = ST_IDLE;
					end
					ST_RECEIVE: begin
						r.driver_cmd = CMD_RX_ON;
						ack_due = 1'b0;
						if (ev.driver_ok) st = ST_RECEIVING;
						else st = ST_IDLE;
					end
					ST_PROCESS: begin
						st = ST_IDLE;
						if (in_valid) begin
							if (cfg_root && out_valid && out_dest == in_source)
								st = ST_SEND;
							r.deliver = (in_type == MT_DATA) ? DLV_DATA : DLV_CMD;
							r.deliver_rssi = in_rssi;
							r.deliver_source = in_source;
							in_valid = 1'b0;
							in_type = '0;
							in_source = '0;
							in_rssi = '0;
						end
					end
					ST_SEND: begin
						if (!out_valid) begin
							if (cfg_root) st = ST_RECEIVE;
							else st = ST_IDLE;
						end else begin
							r.driver_cmd = CMD_SEND;
							if (ev.driver_ok) st = ST_SENDING;
							else st = ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (out_valid) st = ST_SEND;
						else if (cfg_root) st = ST_RECEIVE;
						else r.driver_cmd = CMD_STANDBY;
					end
					default: ;
				endcase
			end
			KIND_PKT: begin
				if (ev.length >= HEADER_BYTES && ev.dest_id == cfg_node) begin
					if (ev.pkt_type == MT_ACK && st == ST_WAIT_ACK) begin
						if (ev.ack_num == out_number)
							out_valid = 1'b0;
						r.driver_cmd = CMD_RX_OFF;
					end else if ((ev.pkt_type == MT_DATA || ev.pkt_type == MT_CMD) &&
							st == ST_RECEIVING) begin
						in_valid = 1'b1;
						in_type = ev.pkt_type;
						in_source = ev.src_addr;
						in_rssi = ev.rssi;
						ack_dest = ev.src_addr;
						ack_number = ev.msg_num;
						ack_due = 1'b1;
						r.driver_cmd = CMD_RX_OFF;
					end
				end
			end
			KIND_RX_DONE: begin
				if (st == ST_WAIT_ACK) begin
					if (cfg_root) st = ST_IDLE;
					else st = ST_RECEIVE;
				end else if (st == ST_RECEIVING) begin
					if (ack_due) begin
						r.driver_cmd = CMD_SEND_ACK;
						r.reply_dest = ack_dest;
						r.reply_num = ack_number;
						if (ev.driver_ok) st = ST_SENDING_ACK;
						else st = ST_PROCESS;
					end else begin
						st = ST_IDLE;
					end
				end
			end
			KIND_TX_DONE: begin
				if (st == ST_SENDING) begin
					if (ev.sent_flag) begin
						r.driver_cmd = CMD_RX_ON;
						if (ev.driver_ok) st = ST_WAIT_ACK;
						else st = ST_IDLE;
					end else begin
						st = ST_IDLE;
					end
				end else if (st == ST_SENDING_ACK) begin
					st = ST_PROCESS;
				end
			end
			KIND_APP_DATA: r.append_accepted = take_append(ev, MAX_PAYLOAD);
			KIND_APP_CMD:  r.append_accepted = take_append(ev, MAX_CMD_PARAMS);
			default: ;
		endcase
		r.link_state = st;
		r.outgoing_pending = out_valid;
		r.outgoing_num = out_valid ? out_number : 8'd0;
		return r;
	endfunction

	function automatic in_item_t link_event(input logic [2:0] kind, input logic [7:0] length,
			input logic [1:0] mtype, input logic [31:0] dest, input logic [31:0] src,
			input logic [7:0] mnum, input logic [7:0] anum, input logic [7:0] rssi,
			input logic sent, input logic ok);
		in_item_t ev;
		ev.kind = kind;
		ev.length = length;
		ev.pkt_type = mtype;
		ev.dest_id = dest;
		ev.src_addr = src;
		ev.msg_num = mnum;
		ev.ack_num = anum;
		ev.rssi = rssi;
		ev.sent_flag = sent;
		ev.driver_ok = ok;
		return ev;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// small address pool so that outgoing destinations and incoming sources collide
	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0001;
			1: return 32'h8000_0002;
			2: return cfg_node ^ 32'h1;
			default: return $urandom();
		endcase
	endfunction

	// mostly the event that moves the current state forward, the rest pure noise
	function automatic in_item_t next_event();
		in_item_t ev;
		ev.kind = 3'($urandom_range(0, 7));
		ev.length = 8'($urandom());
		ev.pkt_type = 2'($urandom());
		ev.dest_id = ($urandom_range(0, 3) == 0) ? cfg_node : $urandom();
		ev.src_addr = $urandom();
		ev.msg_num = 8'($urandom());
		ev.ack_num = 8'($urandom());
		ev.rssi = 8'($urandom());
		ev.sent_flag = 1'($urandom());
		ev.driver_ok = 1'($urandom());
		if ($urandom_range(0, 99) < noise_pct)
			return ev;
		ev.driver_ok = ($urandom_range(0, 99) >= fail_pct);
		ev.sent_flag = ($urandom_range(0, 99) >= fail_pct);
		case (st)
			ST_IDLE: begin
				if (!out_valid && $urandom_range(0, 3) != 0) begin
					if ($urandom_range(0, 1) != 0) begin
						ev.kind = KIND_APP_DATA;
						ev.length = 8'($urandom_range(1, MAX_PAYLOAD));
					end else begin
						ev.kind = KIND_APP_CMD;
						ev.length = 8'($urandom_range(1, MAX_CMD_PARAMS));
					end
					ev.dest_id = pick_addr();
				end else begin
					ev.kind = KIND_TICK;
				end
			end
			ST_RECEIVING: begin
				if (!out_valid && $urandom_range(0, 4) == 0) begin
					ev.kind = KIND_APP_DATA;
					ev.length = 8'($urandom_range(1, MAX_PAYLOAD));
					ev.dest_id = pick_addr();
				end else if (!ack_due && $urandom_range(0, 4) != 0) begin
					ev.kind = KIND_PKT;
					ev.length = 8'($urandom_range(HEADER_BYTES, 255));
					ev.pkt_type = ($urandom_range(0, 1) != 0) ? MT_CMD : MT_DATA;
					ev.dest_id = cfg_node;
					ev.src_addr = pick_addr();
				end else begin
					ev.kind = KIND_RX_DONE;
				end
			end
			ST_SENDING, ST_SENDING_ACK: ev.kind = KIND_TX_DONE;
			ST_WAIT_ACK: begin
				if (out_valid && $urandom_range(0, 4) != 0) begin
					ev.kind = KIND_PKT;
					ev.length = 8'($urandom_range(HEADER_BYTES, 255));
					ev.pkt_type = MT_ACK;
					ev.dest_id = cfg_node;
					ev.ack_num = ($urandom_range(0, 9) != 0) ? out_number : 8'($urandom());
				end else begin
					ev.kind = KIND_RX_DONE;
				end
			end
			default: ev.kind = KIND_TICK;
		endcase
		return ev;
	endfunction

	task automatic send_event(input in_item_t ev);
		int gap;
		gap = idling ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= ev.kind;
		s_tdata <= {4'b0, ev.driver_ok, ev.sent_flag, ev.rssi, ev.ack_num, ev.msg_num,
			ev.src_addr, ev.dest_id, ev.pkt_type, ev.length};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		link_reports_due.push_back(predict_link_step(ev));
	endtask

	task automatic run_traffic(input int count);
		repeat (count) send_event(next_event());
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (link_reports_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input bit root, input logic [31:0] node);
		drain();
		reg_write(ADDR_ROOT_MODE, {31'b0, root});
		cfg_root = root;
		reg_write(ADDR_NODE_ID, node);
		cfg_node = node;
	endtask

	// leaf mode at reset values: spare kinds, stray events, append limits, unmatched ack,
	// short and long packets, full receive-ack-deliver path
	task automatic test_directed_leaf();
		send_event(link_event(KIND_SPARE_6, 8'hFF, MT_OTHER, '1, '1, '1, '1, 8'h7F, 1'b1, 1'b1));
		send_event(link_event(KIND_SPARE_7, 8'h00, MT_DATA, '0, '0, '0, '0, 8'h80, 1'b0, 1'b0));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_RX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b1, 1'b1));
		send_event(link_event(KIND_TX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b1, 1'b1));
		send_event(link_event(KIND_PKT, 8'd20, MT_DATA, cfg_node, 32'h5, 8'd1, '0, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_APP_DATA, 8'd0, MT_DATA, 32'h7, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_APP_DATA, 8'(MAX_PAYLOAD + 1), MT_DATA, 32'h7, '0, '0, '0,
			'0, 1'b0, 1'b1));
		send_event(link_event(KIND_APP_CMD, 8'(MAX_CMD_PARAMS + 1), MT_DATA, 32'h7, '0, '0, '0,
			'0, 1'b0, 1'b1));
		send_event(link_event(KIND_APP_CMD, 8'(MAX_CMD_PARAMS), MT_DATA, '0, '0, '0, '0, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_APP_DATA, 8'(MAX_PAYLOAD), MT_DATA, '1, '0, '0, '0, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_TX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b1, 1'b1));
		send_event(link_event(KIND_PKT, 8'(HEADER_BYTES - 1), MT_ACK, cfg_node, '0, '0, '0, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_PKT, 8'(HEADER_BYTES), MT_ACK, cfg_node, '0, '0, 8'd5, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_PKT, 8'd255, MT_ACK, cfg_node, '0, '0, 8'd0, '0,
			1'b0, 1'b1));
		send_event(link_event(KIND_RX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_PKT, 8'(HEADER_BYTES), MT_CMD, cfg_node, '1, 8'hFF, '0,
			8'h80, 1'b0, 1'b1));
		send_event(link_event(KIND_RX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
		send_event(link_event(KIND_TX_DONE, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b0));
		send_event(link_event(KIND_TICK, 8'd0, MT_DATA, '0, '0, '0, '0, '0, 1'b0, 1'b1));
	endtask

	task automatic test_leaf_traffic();
		configure(1'b0, $urandom());
		noise_pct = 25;
		fail_pct = 10;
		run_traffic(120);
	endtask

	task automatic test_root_backpressure();
		configure(1'b1, 32'h0000_0000);
		noise_pct = 20;
		fail_pct = 10;
		run_traffic(40);
		hold_req = 1'b1;
		run_traffic(100);
	endtask

	task automatic test_back_to_back();
		configure(1'b0, NODE_ID_RESET);
		idling = 1'b0;
		noise_pct = 20;
		run_traffic(80);
		idling = 1'b1;
	endtask

	// park in wait ack, then alternate matched ack and append until the number has wrapped and reached 4
	task automatic test_number_wrap();
		configure(1'b1, $urandom());
		noise_pct = 0;
		fail_pct = 0;
		while (st != ST_WAIT_ACK || !out_valid)
			send_event(next_event());
		while (!number_wrapped || next_number < 8'd4) begin
			send_event(link_event(KIND_PKT, 8'(HEADER_BYTES), MT_ACK, cfg_node, '0, '0,
				out_number, '0, 1'b0, 1'b1));
			send_event(link_event(KIND_APP_CMD, 8'($urandom_range(1, MAX_CMD_PARAMS)), MT_CMD,
				pick_addr(), '0, '0, '0, '0, 1'b0, 1'b1));
		end
	endtask

	task automatic test_mixed_traffic();
		configure(1'b0, NODE_ID_RESET);
		noise_pct = 50;
		fail_pct = 25;
		run_traffic(50);
		configure(1'b1, NODE_ID_RESET);
		run_traffic(50);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("report %0d %s: expected %0h, got %0h", reports_seen, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_r.link_state = m_tdata[3:0];
			got_r.driver_cmd = m_tdata[6:4];
			got_r.deliver = m_tdata[8:7];
			got_r.deliver_rssi = m_tdata[16:9];
			got_r.deliver_source = m_tdata[48:17];
			got_r.reply_dest = m_tdata[80:49];
			got_r.reply_num = m_tdata[88:81];
			got_r.append_accepted = m_tdata[89];
			got_r.outgoing_pending = m_tdata[90];
			got_r.outgoing_num = m_tdata[98:91];
			if (link_reports_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d unexpected: %h", reports_seen, m_tdata);
			end else begin
				want_r = link_reports_due.pop_front();
				check_field("link_state", 32'(want_r.link_state), 32'(got_r.link_state));
				check_field("driver_cmd", 32'(want_r.driver_cmd), 32'(got_r.driver_cmd));
				check_field("deliver", 32'(want_r.deliver), 32'(got_r.deliver));
				check_field("deliver_rssi", 32'(want_r.deliver_rssi),
					32'(got_r.deliver_rssi));
				check_field("deliver_source", want_r.deliver_source, got_r.deliver_source);
				check_field("reply_dest", want_r.reply_dest, got_r.reply_dest);
				check_field("reply_num", 32'(want_r.reply_num), 32'(got_r.reply_num));
				check_field("append_accepted", 32'(want_r.append_accepted),
					32'(got_r.append_accepted));
				check_field("outgoing_pending", 32'(want_r.outgoing_pending),
					32'(got_r.outgoing_pending));
				check_field("outgoing_num", 32'(want_r.outgoing_num),
					32'(got_r.outgoing_num));
			end
			reports_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idling && $urandom_range(0, 99) < 15) begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_leaf();
		test_leaf_traffic();
		test_root_backpressure();
		test_back_to_back();
		test_number_wrap();
		test_mixed_traffic();
		drain();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/rswl_pkg.sv
rtl/rswl_cfg.sv
rtl/rswl_step.sv
rtl/radio_stop_and_wait_link.sv
rtl/rswl_checker.sv
tb/tb.sv
